// ===== hdl/jsu_pkg.sv =====
package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef enum logic [2:0] {
    MODE_OUTSIDE,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_HEX_FIRST,
    MODE_WANT_BSL,
    MODE_WANT_U,
    MODE_HEX_SECOND
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_TRUNC,
    ERR_BAD_HEX,
    ERR_LONE_LOW,
    ERR_NO_BSL,
    ERR_NO_U,
    ERR_BAD_LOW
  } err_t;

  // One queued command: up to four output bytes, or a single error result.
  typedef struct packed {
    logic            is_err;
    err_t            err;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [1:0]      nm1;
    logic [3:0][7:0] b;
  } utf8_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u.nm1 = 2'd0;
    u.b   = '0;
    if (cp < 21'h80) begin
      u.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      u.nm1  = 2'd1;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.nm1  = 2'd2;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.nm1  = 2'd3;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

// ===== hdl/jsu_front.sv =====
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [7:0]    in_byte,
  input  logic          in_eot,
  output logic          push,
  output jsu_pkg::cmd_t push_cmd
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [15:0]    acc_r, acc_nxt;
  logic [9:0]     hi_r, hi_nxt;
  logic           bad_r, bad_nxt;
  logic           disc_r, disc_nxt;

  jsu_pkg::hex_t  hx;
  jsu_pkg::utf8_t enc;
  jsu_pkg::err_t  err;
  logic [15:0]    acc_new;
  logic           bad_new;
  logic [20:0]    cp;
  logic           is_bsl, is_quote, is_slash, is_u;
  logic           is_surr, is_low, last_digit;

  assign is_bsl     = (in_byte == jsu_pkg::CH_BSL);
  assign is_quote   = (in_byte == jsu_pkg::CH_QUOTE);
  assign is_slash   = (in_byte == jsu_pkg::CH_SLASH);
  assign is_u       = (in_byte == jsu_pkg::CH_U);
  assign hx         = jsu_pkg::hex_decode(in_byte);
  assign acc_new    = {acc_r[11:0], hx.ok ? hx.val : 4'd0};
  assign bad_new    = bad_r | ~hx.ok;
  assign is_surr    = (acc_new[15:11] == 5'b11011);
  assign is_low     = (acc_new[15:10] == 6'b110111);
  assign last_digit = (cnt_r == 2'd3);
  assign cp = (mode_r == jsu_pkg::MODE_HEX_SECOND) ?
              21'h10000 + {1'b0, hi_r, acc_new[9:0]} : {5'd0, acc_new};
  assign enc = jsu_pkg::utf8_encode(cp);

  // Datapath and command output
  always_comb begin
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    hi_nxt   = hi_r;
    bad_nxt  = bad_r;
    disc_nxt = disc_r;
    err      = jsu_pkg::ERR_NONE;
    push     = 1'b0;
    push_cmd = '0;
    if (in_fire) begin
      if (disc_r) begin
        if (in_eot) begin
          disc_nxt = 1'b0;
        end
      end else begin
        case (mode_r)
          jsu_pkg::MODE_STRING: begin
            if (is_bsl) begin
              if (in_eot) err = jsu_pkg::ERR_TRUNC;
            end else begin
              push              = 1'b1;
              push_cmd.bytes[0] = in_byte;
            end
          end
          jsu_pkg::MODE_ESCAPE: begin
            if (is_slash) begin
              push              = 1'b1;
              push_cmd.bytes[0] = in_byte;
            end else if (is_u) begin
              if (in_eot) err = jsu_pkg::ERR_TRUNC;
              cnt_nxt = 2'd0;
              acc_nxt = '0;
              bad_nxt = 1'b0;
            end else begin
              push              = 1'b1;
              push_cmd.last_idx = 2'd1;
              push_cmd.bytes[0] = jsu_pkg::CH_BSL;
              push_cmd.bytes[1] = in_byte;
            end
          end
          jsu_pkg::MODE_HEX_FIRST, jsu_pkg::MODE_HEX_SECOND: begin
            if (!last_digit) begin
              cnt_nxt = cnt_r + 2'd1;
              acc_nxt = acc_new;
              bad_nxt = bad_new;
              if (in_eot) err = jsu_pkg::ERR_TRUNC;
            end else if (bad_new) begin
              err = jsu_pkg::ERR_BAD_HEX;
            end else if (mode_r == jsu_pkg::MODE_HEX_FIRST) begin
              cnt_nxt = 2'd0;
              acc_nxt = '0;
              bad_nxt = 1'b0;
              if (!is_surr) begin
                push              = 1'b1;
                push_cmd.last_idx = enc.nm1;
                push_cmd.bytes    = enc.b;
              end else if (is_low) begin
                err = jsu_pkg::ERR_LONE_LOW;
              end else begin
                hi_nxt = acc_new[9:0];
                if (in_eot) err = jsu_pkg::ERR_NO_BSL;
              end
            end else begin
              if (!is_low) begin
                err = jsu_pkg::ERR_BAD_LOW;
              end else begin
                push              = 1'b1;
                push_cmd.last_idx = enc.nm1;
                push_cmd.bytes    = enc.b;
                cnt_nxt           = 2'd0;
                acc_nxt           = '0;
                bad_nxt           = 1'b0;
                hi_nxt            = '0;
              end
            end
          end
          jsu_pkg::MODE_WANT_BSL: begin
            if (!is_bsl) err = jsu_pkg::ERR_NO_BSL;
            else if (in_eot) err = jsu_pkg::ERR_NO_U;
          end
          jsu_pkg::MODE_WANT_U: begin
            if (!is_u) begin
              err = jsu_pkg::ERR_NO_U;
            end else if (in_eot) begin
              err = jsu_pkg::ERR_TRUNC;
            end else begin
              cnt_nxt = 2'd0;
              acc_nxt = '0;
              bad_nxt = 1'b0;
            end
          end
          default: begin
            push              = 1'b1;
            push_cmd.bytes[0] = in_byte;
          end
        endcase

        // An error replaces any bytes and restarts the parser
        if (err != jsu_pkg::ERR_NONE) begin
          push            = 1'b1;
          push_cmd        = '0;
          push_cmd.is_err = 1'b1;
          push_cmd.err    = err;
          disc_nxt        = !in_eot;
        end
        if (err != jsu_pkg::ERR_NONE || in_eot) begin
          cnt_nxt = 2'd0;
          acc_nxt = '0;
          bad_nxt = 1'b0;
          hi_nxt  = '0;
        end
      end
    end
  end

  // Next parse mode
  always_comb begin
    mode_nxt = mode_r;
    if (in_fire) begin
      if (disc_r) begin
        if (in_eot) mode_nxt = jsu_pkg::MODE_OUTSIDE;
      end else if (err != jsu_pkg::ERR_NONE || in_eot) begin
        mode_nxt = jsu_pkg::MODE_OUTSIDE;
      end else begin
        case (mode_r)
          jsu_pkg::MODE_STRING: begin
            if (is_bsl) mode_nxt = jsu_pkg::MODE_ESCAPE;
            else if (is_quote) mode_nxt = jsu_pkg::MODE_OUTSIDE;
          end
          jsu_pkg::MODE_ESCAPE: begin
            mode_nxt = is_u ? jsu_pkg::MODE_HEX_FIRST : jsu_pkg::MODE_STRING;
          end
          jsu_pkg::MODE_HEX_FIRST: begin
            if (last_digit) begin
              mode_nxt = is_surr ? jsu_pkg::MODE_WANT_BSL : jsu_pkg::MODE_STRING;
            end
          end
          jsu_pkg::MODE_WANT_BSL:   mode_nxt = jsu_pkg::MODE_WANT_U;
          jsu_pkg::MODE_WANT_U:     mode_nxt = jsu_pkg::MODE_HEX_SECOND;
          jsu_pkg::MODE_HEX_SECOND: begin
            if (last_digit) mode_nxt = jsu_pkg::MODE_STRING;
          end
          default: begin
            mode_nxt = is_quote ? jsu_pkg::MODE_STRING : jsu_pkg::MODE_OUTSIDE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_OUTSIDE;
      cnt_r  <= '0;
      acc_r  <= '0;
      hi_r   <= '0;
      bad_r  <= 1'b0;
      disc_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      hi_r   <= hi_nxt;
      bad_r  <= bad_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

// ===== hdl/jsu_queue.sv =====
module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jsu_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output jsu_pkg::cmd_t    head,
  output jsu_pkg::q_stat_t stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t slot_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign head       = slot_r[rd_r];
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CW'(DEPTH))
    else $error("queue pushed while full");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

// ===== hdl/jsu_back.sv =====
module jsu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  jsu_pkg::cmd_t    head,
  input  jsu_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_last,
  output jsu_pkg::err_t    out_err
);

  logic [1:0]    idx_r, idx_nxt;
  logic          vld_r, vld_nxt;
  logic [7:0]    byte_r;
  logic          bval_r;
  logic          last_r;
  jsu_pkg::err_t err_r;
  logic          load, take, is_last;

  assign load    = !vld_r || out_tready;
  assign take    = load && !stat.empty;
  assign is_last = (idx_r == head.last_idx);
  assign pop     = take && is_last;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = !stat.empty;
      if (take) idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= head.bytes[idx_r];
      bval_r <= !head.is_err;
      last_r <= is_last;
      err_r  <= head.err;
    end
  end

  assign out_tvalid     = vld_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bval_r;
  assign out_last       = last_r;
  assign out_err        = err_r;

`ifndef SYNTHESIS
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !bval_r) |-> (last_r && err_r != jsu_pkg::ERR_NONE && byte_r == 8'd0))
    else $error("error result malformed");
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && bval_r) |-> err_r == jsu_pkg::ERR_NONE)
    else $error("data result carries an error code");
`endif

endmodule

// ===== hdl/json_string_unescaper.sv =====
// Channel | Dir | Handshake            | Payload
// in_     | in  | in_tvalid/in_tready  | in_tdata[7:0]=in_byte, in_tlast=end_of_text
// out_    | out | out_tvalid/out_tready| out_tdata[7:0]=out_byte, out_tlast=last_of_run,
//         |     |                      | out_tuser[0]=byte_valid, out_tuser[3:1]=error_code
//
// Cycles: one input transfer per cycle while the command queue has room; with an
//   empty queue a transfer's first result is registered in the queue, then in the output
//   register; an escape that expands to more than one result holds the back end, one result per cycle.
// Reset: rst_n synchronous, active low; no clearing pass, in_tready high right after.
// Stalls: out_tready low holds the output register; input stalls only when the
//   QUEUE_DEPTH-entry command queue is full.
module json_string_unescaper #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [3:0] out_tuser   // [0] byte_valid, [3:1] error_code
);

  logic             in_fire;
  logic             push;
  logic             pop;
  jsu_pkg::cmd_t    push_cmd;
  jsu_pkg::cmd_t    head;
  jsu_pkg::q_stat_t stat;
  logic             out_bval;
  jsu_pkg::err_t    out_err;

  // Take a transfer whenever the queue has room for its command
  assign in_tready = !stat.full;
  assign in_fire   = in_tvalid && in_tready;

  // Front: parse and classify each byte into a command
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_tdata),
    .in_eot   (in_tlast),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple parsing from serialization
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  // Back: serialize each command into result transfers
  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .stat           (stat),
    .pop            (pop),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_byte       (out_tdata),
    .out_byte_valid (out_bval),
    .out_last       (out_tlast),
    .out_err        (out_err)
  );

  assign out_tuser = {out_err, out_bval};

endmodule

// ===== tb/unescape_checker.sv =====
`timescale 1ns / 100ps

module unescape_checker
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_byte
  input  logic       out_tlast,
  input  logic [3:0] out_tuser,  // [0] byte_valid, [3:1] error_code
  output int         mismatch_total,
  output int         results_owed
);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    err_t       err;
  } result_t;

  result_t    owed_results[$];
  result_t    burst[$];
  int         mismatches = 0;
  int         checked = 0;

  // Parser copy
  mode_t      mode = MODE_OUTSIDE;
  logic [1:0] digits = '0;
  logic [15:0] acc = '0;
  logic [15:0] high_half = '0;
  logic       bad_hex = 1'b0;
  logic       discard = 1'b0;

  function automatic void clear_escape();
    digits  = '0;
    acc     = '0;
    bad_hex = 1'b0;
  endfunction

  function automatic void reset_parser();
    mode      = MODE_OUTSIDE;
    clear_escape();
    high_half = '0;
    discard   = 1'b0;
  endfunction

  function automatic void emit(input logic [7:0] b);
    burst.push_back('{b, 1'b1, 1'b0, ERR_NONE});
  endfunction

  function automatic void emit_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]});
      emit({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit({4'b1110, cp[15:12]});
      emit({2'b10, cp[11:6]});
      emit({2'b10, cp[5:0]});
    end else begin
      emit({5'b11110, cp[20:18]});
      emit({2'b10, cp[17:12]});
      emit({2'b10, cp[11:6]});
      emit({2'b10, cp[5:0]});
    end
  endfunction

  // bit 4 flags a character that is not a hex digit
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  // Shift in one digit; true once the fourth digit is in.
  function automatic logic take_digit(input logic [7:0] c);
    logic [4:0] v;
    v = digit_value(c);
    if (v[4]) bad_hex = 1'b1;
    acc = {acc[11:0], v[4] ? 4'h0 : v[3:0]};
    if (digits == 2'd3) return 1'b1;
    digits = digits + 2'd1;
    return 1'b0;
  endfunction

  task automatic unescape_byte(input logic [7:0] c, input logic eot);
    err_t    err;
    logic    full;
    result_t r;
    err = ERR_NONE;
    burst.delete();
    if (discard) begin
      if (eot) reset_parser();
      return;
    end
    case (mode)
      MODE_STRING: begin
        if (c == CH_BSL) begin
          if (eot) err = ERR_TRUNC;
          else mode = MODE_ESCAPE;
        end else begin
          if (c == CH_QUOTE) mode = MODE_OUTSIDE;
          emit(c);
        end
      end
      MODE_ESCAPE: begin
        if (c == CH_SLASH) begin
          emit(c);
          mode = MODE_STRING;
        end else if (c == CH_U) begin
          if (eot) err = ERR_TRUNC;
          clear_escape();
          mode = MODE_HEX_FIRST;
        end else begin
          emit(CH_BSL);
          emit(c);
          mode = MODE_STRING;
        end
      end
      MODE_HEX_FIRST: begin
        full = take_digit(c);
        if (!full) begin
          if (eot) err = ERR_TRUNC;
        end else if (bad_hex) begin
          err = ERR_BAD_HEX;
        end else if (acc < 16'hD800 || acc > 16'hDFFF) begin
          emit_utf8({5'd0, acc});
          mode = MODE_STRING;
          clear_escape();
        end else if (acc >= 16'hDC00) begin
          err = ERR_LONE_LOW;
        end else begin
          high_half = acc;
          clear_escape();
          mode = MODE_WANT_BSL;
          if (eot) err = ERR_NO_BSL;
        end
      end
      MODE_WANT_BSL: begin
        if (c != CH_BSL) err = ERR_NO_BSL;
        else if (eot) err = ERR_NO_U;
        else mode = MODE_WANT_U;
      end
      MODE_WANT_U: begin
        if (c != CH_U) begin
          err = ERR_NO_U;
        end else if (eot) begin
          err = ERR_TRUNC;
        end else begin
          clear_escape();
          mode = MODE_HEX_SECOND;
        end
      end
      MODE_HEX_SECOND: begin
        full = take_digit(c);
        if (!full) begin
          if (eot) err = ERR_TRUNC;
        end else if (bad_hex) begin
          err = ERR_BAD_HEX;
        end else if (acc < 16'hDC00 || acc > 16'hDFFF) begin
          err = ERR_BAD_LOW;
        end else begin
          // both halves carry 10 payload bits each
          emit_utf8(21'h10000 + {1'b0, high_half[9:0], acc[9:0]});
          mode = MODE_STRING;
          clear_escape();
          high_half = '0;
        end
      end
      default: begin
        mode = (c == CH_QUOTE) ? MODE_STRING : MODE_OUTSIDE;
        emit(c);
      end
    endcase

    if (err != ERR_NONE) begin
      burst.delete();
      burst.push_back('{8'h00, 1'b0, 1'b0, err});
      reset_parser();
      discard = !eot;
    end else if (eot) begin
      reset_parser();
    end

    foreach (burst[i]) begin
      r = burst[i];
      r.last = (i == burst.size() - 1);
      owed_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    logic    bad;
    if (!rst_n) begin
      reset_parser();
      owed_results.delete();
    end else begin
      // results on the output register come from earlier transfers, so check first
      if (out_tvalid && out_tready) begin
        checked++;
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: none owed, got data=%02h valid=%0b last=%0b err=%0d",
                     checked, out_tdata, out_tuser[0], out_tlast, out_tuser[3:1]);
        end else begin
          want = owed_results.pop_front();
          bad  = (out_tdata !== want.data) || (out_tuser[0] !== want.valid) ||
                 (out_tlast !== want.last) || (out_tuser[3:1] !== want.err);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("result %0d: want data=%02h valid=%0b last=%0b err=%0d, ",
                     checked, want.data, want.valid, want.last, want.err);
              $display("got data=%02h valid=%0b last=%0b err=%0d",
                       out_tdata, out_tuser[0], out_tlast, out_tuser[3:1]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) unescape_byte(in_tdata, in_tlast);
    end
    results_owed   <= owed_results.size();
    mismatch_total <= mismatches;
  end

endmodule

// ===== tb/tb_json_string_unescaper.sv =====
`timescale 1ns / 100ps

module tb_json_string_unescaper;
  import jsu_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_BYTES = 140;
  localparam int IDLE_PCT     = 28;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;    // [7:0] in_byte
  logic       in_tlast = 1'b0;  // end of one JSON text
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;        // [7:0] out_byte
  logic       out_tlast;
  logic [3:0] out_tuser;        // [0] byte_valid, [3:1] error_code

  int         fail_count;
  int         results_owed;
  int         cycles = 0;
  logic       calm = 1'b0;      // high: neither side idles
  logic [7:0] text_q[$];        // one JSON text, sent with tlast on its final byte

  json_string_unescaper uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  unescape_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .mismatch_total(fail_count),
    .results_owed  (results_owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stall at random, except during the calm stretch.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one byte, optionally after a random idle gap, and hold it until the
  // transfer completes. tvalid is left high so back-to-back bytes need no gap.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Send the queued text, marking its final byte as end of text.
  task automatic send_text(inout int sent);
    foreach (text_q[i]) begin
      send_byte(text_q[i], i == text_q.size() - 1);
      sent++;
    end
  endtask

  function automatic void load_string(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Random byte and random 16-bit code unit, sized to their targets
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] rand_unit(input int unsigned hi, input int unsigned lo);
    return 16'($urandom_range(hi, lo));
  endfunction

  // ASCII hex digit, letters in random case
  function automatic logic [7:0] hex_ascii(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    c = rand_byte();
    while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46))
      c = rand_byte();
    return c;
  endfunction

  // Append a backslash-u escape; the digit at bad_pos (0..3) is spoiled,
  // any other bad_pos leaves all four digits valid.
  function automatic void push_escape(input logic [15:0] unit, input int bad_pos);
    text_q.push_back(CH_BSL);
    text_q.push_back(CH_U);
    for (int i = 0; i < 4; i++)
      text_q.push_back((i == bad_pos) ? non_hex() : hex_ascii(unit[15 - 4*i -: 4]));
  endfunction

  function automatic void add_segment();
    int          kind;
    logic [7:0]  c;
    logic [15:0] unit;
    kind = $urandom_range(99);
    if (kind < 30) begin
      // plain byte; a quote here closes the string early, which is fine
      c = rand_byte();
      if (c == CH_BSL) c = CH_SLASH;
      text_q.push_back(c);
    end else if (kind < 40) begin
      text_q.push_back(CH_BSL);
      text_q.push_back(CH_SLASH);
    end else if (kind < 50) begin
      // escape that passes on verbatim
      c = rand_byte();
      if (c == CH_U || c == CH_SLASH) c = CH_QUOTE;
      text_q.push_back(CH_BSL);
      text_q.push_back(c);
    end else if (kind < 58) begin
      push_escape(rand_unit(16'hFFFF, 0), $urandom_range(3));
    end else begin
      case ($urandom_range(5))
        0: push_escape(rand_unit(16'h7F, 0), 4);
        1: push_escape(rand_unit(16'h7FF, 16'h80), 4);
        2: begin
          if ($urandom_range(3) == 0) unit = 16'hFFFF;
          else if ($urandom_range(1)) unit = rand_unit(16'hD7FF, 16'h800);
          else unit = rand_unit(16'hFFFF, 16'hE000);
          push_escape(unit, 4);
        end
        3: push_escape(rand_unit(16'hDFFF, 16'hDC00), 4);  // lone low half
        default: begin
          // surrogate pair, mostly well formed
          push_escape(rand_unit(16'hDBFF, 16'hD800), 4);
          case ($urandom_range(9))
            0: begin
              c = rand_byte();
              if (c == CH_BSL) c = CH_U;
              text_q.push_back(c);
            end
            1: begin
              c = rand_byte();
              if (c == CH_U) c = CH_BSL;
              text_q.push_back(CH_BSL);
              text_q.push_back(c);
            end
            2: begin
              if ($urandom_range(1)) unit = rand_unit(16'hDBFF, 0);
              else unit = rand_unit(16'hFFFF, 16'hE000);
              push_escape(unit, 4);
            end
            3: push_escape(rand_unit(16'hDFFF, 16'hDC00), $urandom_range(3));
            default: push_escape(rand_unit(16'hDFFF, 16'hDC00), 4);
          endcase
        end
      endcase
    end
  endfunction

  // Build one random JSON text: mostly a string with escapes, sometimes noise,
  // sometimes cut short so the text may end inside an escape.
  function automatic void build_text();
    int cut;
    text_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(4, 1)) text_q.push_back(rand_byte());
      return;
    end
    if ($urandom_range(4) == 0) text_q.push_back(rand_byte());
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(5, 1)) add_segment();
    if ($urandom_range(3) != 0) begin
      text_q.push_back(CH_QUOTE);
      if ($urandom_range(1)) text_q.push_back(rand_byte());
    end
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(text_q.size(), 1);
      while (text_q.size() > cut) void'(text_q.pop_back());
    end
  endfunction

  initial begin : stimulus
    int sent;
    int drained;
    sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes outside a string
    text_q.delete();
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    send_text(sent);
    // text ends right after a backslash inside a string
    load_string("\"\\");
    send_text(sent);
    // code unit zero
    load_string("\"\\u0000");
    send_text(sent);
    // lone low half, then the rest of the text is dropped
    load_string("\"\\uDC00x");
    send_text(sent);
    // text ends right after a high half
    load_string("\"\\uD800");
    send_text(sent);

    // Random texts, with a calm stretch in the middle
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      build_text();
      calm <= (sent >= 50 && sent < 100);
      send_text(sent);
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    calm      <= 1'b0;

    // let the owed count catch up with the final transfer, then drain
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    drained = 0;
    while (drained < 16) begin
      @(posedge clk);
      drained++;
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
